// ----- src/md5_pkg.sv -----
package md5_pkg;

    typedef struct packed {
        logic [7:0] data_byte;
        logic       has_byte;
        logic       end_of_message;
    } md5_in_t;

    typedef struct packed {
        logic [7:0] digest_byte;
        logic       digest_last;
    } md5_out_t;

    localparam logic [31:0] INIT_A = 32'h67452301;
    localparam logic [31:0] INIT_B = 32'hEFCDAB89;
    localparam logic [31:0] INIT_C = 32'h98BADCFE;
    localparam logic [31:0] INIT_D = 32'h10325476;

    function automatic logic [31:0] round_k(input logic [5:0] i);
        logic [31:0] k;
        begin
            case (i)
                6'd0: k = 32'hd76aa478;  6'd1: k = 32'he8c7b756;
                6'd2: k = 32'h242070db;  6'd3: k = 32'hc1bdceee;
                6'd4: k = 32'hf57c0faf;  6'd5: k = 32'h4787c62a;
                6'd6: k = 32'ha8304613;  6'd7: k = 32'hfd469501;
                6'd8: k = 32'h698098d8;  6'd9: k = 32'h8b44f7af;
                6'd10: k = 32'hffff5bb1; 6'd11: k = 32'h895cd7be;
                6'd12: k = 32'h6b901122; 6'd13: k = 32'hfd987193;
                6'd14: k = 32'ha679438e; 6'd15: k = 32'h49b40821;
                6'd16: k = 32'hf61e2562; 6'd17: k = 32'hc040b340;
                6'd18: k = 32'h265e5a51; 6'd19: k = 32'he9b6c7aa;
                6'd20: k = 32'hd62f105d; 6'd21: k = 32'h02441453;
                6'd22: k = 32'hd8a1e681; 6'd23: k = 32'he7d3fbc8;
                6'd24: k = 32'h21e1cde6; 6'd25: k = 32'hc33707d6;
                6'd26: k = 32'hf4d50d87; 6'd27: k = 32'h455a14ed;
                6'd28: k = 32'ha9e3e905; 6'd29: k = 32'hfcefa3f8;
                6'd30: k = 32'h676f02d9; 6'd31: k = 32'h8d2a4c8a;
                6'd32: k = 32'hfffa3942; 6'd33: k = 32'h8771f681;
                6'd34: k = 32'h6d9d6122; 6'd35: k = 32'hfde5380c;
                6'd36: k = 32'ha4beea44; 6'd37: k = 32'h4bdecfa9;
                6'd38: k = 32'hf6bb4b60; 6'd39: k = 32'hbebfbc70;
                6'd40: k = 32'h289b7ec6; 6'd41: k = 32'heaa127fa;
                6'd42: k = 32'hd4ef3085; 6'd43: k = 32'h04881d05;
                6'd44: k = 32'hd9d4d039; 6'd45: k = 32'he6db99e5;
                6'd46: k = 32'h1fa27cf8; 6'd47: k = 32'hc4ac5665;
                6'd48: k = 32'hf4292244; 6'd49: k = 32'h432aff97;
                6'd50: k = 32'hab9423a7; 6'd51: k = 32'hfc93a039;
                6'd52: k = 32'h655b59c3; 6'd53: k = 32'h8f0ccc92;
                6'd54: k = 32'hffeff47d; 6'd55: k = 32'h85845dd1;
                6'd56: k = 32'h6fa87e4f; 6'd57: k = 32'hfe2ce6e0;
                6'd58: k = 32'ha3014314; 6'd59: k = 32'h4e0811a1;
                6'd60: k = 32'hf7537e82; 6'd61: k = 32'hbd3af235;
                6'd62: k = 32'h2ad7d2bb; default: k = 32'heb86d391;
            endcase
            return k;
        end
    endfunction

    function automatic logic [4:0] round_s(input logic [5:0] i);
        logic [4:0] s;
        begin
            case ({i[5:4], i[1:0]})
                4'd0: s = 5'd7;   4'd1: s = 5'd12;  4'd2: s = 5'd17;  4'd3: s = 5'd22;
                4'd4: s = 5'd5;   4'd5: s = 5'd9;   4'd6: s = 5'd14;  4'd7: s = 5'd20;
                4'd8: s = 5'd4;   4'd9: s = 5'd11;  4'd10: s = 5'd16; 4'd11: s = 5'd23;
                4'd12: s = 5'd6;  4'd13: s = 5'd10; 4'd14: s = 5'd15; default: s = 5'd21;
            endcase
            return s;
        end
    endfunction

    // message word index used by round i
    function automatic logic [3:0] round_g(input logic [5:0] i);
        logic [3:0] g;
        begin
            case (i[5:4])
                2'd0: g = i[3:0];
                2'd1: g = 4'(i[3:0] * 4'd5 + 4'd1);
                2'd2: g = 4'(i[3:0] * 4'd3 + 4'd5);
                default: g = 4'(i[3:0] * 4'd7);
            endcase
            return g;
        end
    endfunction

endpackage

// ----- src/md5_message_digest.sv -----
// MD5 digest engine. Requests carry one message byte (has_byte) and/or an
// end-of-message flag; an item with neither flag does nothing. Bytes land in a
// 16 x 32-bit block memory, one byte lane written per request; the byte that
// completes a block starts its compression. A full block is compressed with
// one read-ahead step, then one MD5 round per cycle (the message word read
// from the block memory one round ahead), then a fold step that adds the
// round words into the chaining words. On end_of_message the block pads
// the message (0x80, zero fill one word per cycle, 64-bit bit length) and
// compresses one or two more blocks, then sends 16 digest bytes, A byte 0
// first and D byte 3 last, with digest_last on the final byte. A request that
// carries both a byte and the end flag passes through an extra state to place
// the 0x80 after that byte (after the compression when the byte fills a block).
// s_ready is low while a block is compressed, while padding runs and while
// the digest is sent. The block then returns to the initial chaining values.
module md5_message_digest
    import md5_pkg::*;
(
    input  logic     aclk,
    input  logic     aresetn,
    input  logic     s_valid,
    output logic     s_ready,
    input  md5_in_t  s_data,
    output logic     m_valid,
    input  logic     m_ready,
    output md5_out_t m_data
);

    localparam logic [2:0] ST_IDLE  = 3'd0;
    localparam logic [2:0] ST_PAD   = 3'd1; // zero fill / length words
    localparam logic [2:0] ST_PRE   = 3'd2; // first word read
    localparam logic [2:0] ST_ROUND = 3'd3;
    localparam logic [2:0] ST_FOLD  = 3'd4;
    localparam logic [2:0] ST_OUT   = 3'd5;
    localparam logic [2:0] ST_MARK  = 3'd6; // place 0x80 after the last byte

    logic [2:0]  state_reg;
    logic [31:0] ch_reg [4];
    logic [31:0] a_reg, b_reg, c_reg, d_reg;
    logic [60:0] count_reg;
    logic [5:0]  rnd_reg;
    logic        fin_reg;   // message is ending
    logic        last_reg;  // block under compression is the final one
    logic [3:0]  pad_reg;   // next word to fill during padding
    logic [3:0]  ob_reg;    // digest byte index
    logic        ov_reg;

    // block memory: 16 words, byte enables
    logic [31:0] mem [16];
    logic [3:0]  wa;
    logic [31:0] wd;
    logic [3:0]  we;
    logic [3:0]  ra;
    logic [31:0] rd_reg;

    always_ff @(posedge aclk) begin
        for (int i = 0; i < 4; i++) begin
            if (we[i]) begin
                mem[wa][8*i +: 8] <= wd[8*i +: 8];
            end
        end
        rd_reg <= mem[ra];
    end

    logic take;
    assign s_ready = (state_reg == ST_IDLE);
    assign take = s_valid && s_ready;

    logic [5:0]  pos;
    assign pos = count_reg[5:0];
    logic [63:0] bits;
    assign bits = {count_reg, 3'b000};

    // round datapath
    logic [31:0] f, sum, rot;
    logic [4:0]  sh;
    always_comb begin
        case (rnd_reg[5:4])
            2'd0: f = (b_reg & c_reg) | (~b_reg & d_reg);
            2'd1: f = (b_reg & d_reg) | (c_reg & ~d_reg);
            2'd2: f = b_reg ^ c_reg ^ d_reg;
            default: f = c_reg ^ (b_reg | ~d_reg);
        endcase
        sum = a_reg + f + round_k(rnd_reg) + rd_reg;
        sh  = round_s(rnd_reg);
        rot = (sum << sh) | (sum >> (6'd32 - {1'b0, sh}));
    end

    // pad word content for word index w, a word after the one that holds the 0x80
    function automatic logic [31:0] pad_word(input logic [3:0] w, input logic tail,
                                             input logic [63:0] b);
        logic [31:0] v;
        begin
            v = 32'd0;
            if (tail && w == 4'd14) v = b[31:0];
            if (tail && w == 4'd15) v = b[63:32];
            return v;
        end
    endfunction

    always_comb begin
        wa = 4'd0; wd = 32'd0; we = 4'd0;
        ra = round_g(rnd_reg);
        case (state_reg)
            ST_IDLE: begin
                if (take && s_data.has_byte) begin
                    wa = pos[5:2];
                    wd = {4{s_data.data_byte}};
                    we = 4'b0001 << pos[1:0];
                end else if (take && s_data.end_of_message) begin
                    // place 0x80 and clear the rest of its word
                    wa = pos[5:2];
                    wd = 32'h80 << {pos[1:0], 3'b000};
                    we = 4'b1111 << pos[1:0];
                end
                ra = 4'd0;
            end
            ST_MARK: begin
                wa = pos[5:2];
                wd = 32'h80 << {pos[1:0], 3'b000};
                we = 4'b1111 << pos[1:0];
                ra = 4'd0;
            end
            ST_PAD: begin
                wa = pad_reg;
                wd = pad_word(pad_reg, last_reg, bits);
                we = 4'b1111;
                ra = 4'd0;
            end
            ST_PRE: ra = round_g(6'd0);
            ST_ROUND: ra = round_g(6'(rnd_reg + 6'd1));
            default: ra = 4'd0;
        endcase
    end

    logic [60:0] cnt_inc;
    assign cnt_inc = count_reg + 61'd1;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_IDLE;
            ch_reg[0] <= INIT_A; ch_reg[1] <= INIT_B;
            ch_reg[2] <= INIT_C; ch_reg[3] <= INIT_D;
            count_reg <= '0;
            rnd_reg   <= '0;
            fin_reg   <= 1'b0;
            last_reg  <= 1'b0;
            pad_reg   <= '0;
            ob_reg    <= '0;
            ov_reg    <= 1'b0;
        end else begin
            case (state_reg)
                ST_IDLE: begin
                    if (take && s_data.has_byte) begin
                        count_reg <= cnt_inc;
                        fin_reg   <= s_data.end_of_message;
                        if (pos == 6'd63) begin
                            last_reg  <= 1'b0;
                            state_reg <= ST_PRE;
                        end else if (s_data.end_of_message) begin
                            // 0x80 goes right after this byte
                            state_reg <= ST_MARK;
                        end
                    end else if (take && s_data.end_of_message) begin
                        fin_reg   <= 1'b1;
                        last_reg  <= (pos < 6'd56);
                        pad_reg   <= 4'(pos[5:2] + 4'd1);
                        state_reg <= (pos[5:2] == 4'd15) ? ST_PRE : ST_PAD;
                    end
                end
                ST_MARK: begin
                    last_reg  <= (pos < 6'd56);
                    pad_reg   <= 4'(pos[5:2] + 4'd1);
                    state_reg <= (pos[5:2] == 4'd15) ? ST_PRE : ST_PAD;
                end
                ST_PAD: begin
                    if (pad_reg == 4'd15) begin
                        state_reg <= ST_PRE;
                    end else begin
                        pad_reg <= pad_reg + 4'd1;
                    end
                end
                ST_PRE: begin
                    a_reg <= ch_reg[0]; b_reg <= ch_reg[1];
                    c_reg <= ch_reg[2]; d_reg <= ch_reg[3];
                    rnd_reg <= '0;
                    state_reg <= ST_ROUND;
                end
                ST_ROUND: begin
                    a_reg <= d_reg;
                    d_reg <= c_reg;
                    c_reg <= b_reg;
                    b_reg <= b_reg + rot;
                    rnd_reg <= rnd_reg + 6'd1;
                    if (rnd_reg == 6'd63) state_reg <= ST_FOLD;
                end
                ST_FOLD: begin
                    ch_reg[0] <= ch_reg[0] + a_reg;
                    ch_reg[1] <= ch_reg[1] + b_reg;
                    ch_reg[2] <= ch_reg[2] + c_reg;
                    ch_reg[3] <= ch_reg[3] + d_reg;
                    if (last_reg) begin
                        state_reg <= ST_OUT;
                        ob_reg    <= '0;
                        ov_reg    <= 1'b1;
                    end else if (fin_reg) begin
                        if (pos == 6'd0) begin
                            // last byte filled the block: 0x80 opens the next one
                            state_reg <= ST_MARK;
                        end else begin
                            // fresh block: zeros and length only
                            last_reg  <= 1'b1;
                            pad_reg   <= 4'd0;
                            state_reg <= ST_PAD;
                        end
                    end else begin
                        state_reg <= ST_IDLE;
                    end
                end
                ST_OUT: begin
                    if (ov_reg && m_ready) begin
                        ob_reg <= ob_reg + 4'd1;
                        if (ob_reg == 4'd15) begin
                            ov_reg    <= 1'b0;
                            state_reg <= ST_IDLE;
                            fin_reg   <= 1'b0;
                            last_reg  <= 1'b0;
                            count_reg <= '0;
                            ch_reg[0] <= INIT_A; ch_reg[1] <= INIT_B;
                            ch_reg[2] <= INIT_C; ch_reg[3] <= INIT_D;
                        end
                    end
                end
                default: state_reg <= ST_IDLE;
            endcase
        end
    end

    assign m_valid = ov_reg;
    always_comb begin
        m_data.digest_byte = ch_reg[ob_reg[3:2]][8*ob_reg[1:0] +: 8];
        m_data.digest_last = (ob_reg == 4'd15);
    end

`ifndef NO_ASSERTIONS
    a_no_take_busy: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid |-> !s_ready) else $error("input taken while digest pending");
    a_round_span: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == ST_ROUND && rnd_reg == 6'd63) |=> state_reg == ST_FOLD)
        else $error("round counter out of step");
    a_out_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid && !m_ready) |=> m_valid && $stable(ob_reg))
        else $error("digest byte dropped");
`endif

endmodule

// ----- tb/sv/md5_message_digest_tb.sv -----
`timescale 1ns / 100ps

// Self-checking bench for the MD5 digest engine. An initial block builds a
// list of requests (directed messages, then random ones); a clocked driver
// feeds them over the valid/ready input with random gaps, and a clocked
// monitor compares each digest byte with the software digest computed when
// the request was accepted.
module md5_message_digest_tb;
    import md5_pkg::*;

    logic     aclk;
    logic     aresetn;
    logic     s_valid;
    logic     s_ready;
    md5_in_t  s_data;
    logic     m_valid;
    logic     m_ready;
    md5_out_t m_data;

    md5_message_digest dut (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_valid),
        .s_ready (s_ready),
        .s_data  (s_data),
        .m_valid (m_valid),
        .m_ready (m_ready),
        .m_data  (m_data)
    );

    always begin
        aclk = 1'b1;
        #5;
        aclk = 1'b0;
        #5;
    end

    // Pending requests, and digest bytes still owed by the block.
    md5_in_t  pending_requests[$];
    md5_out_t digest_bytes_due[$];
    bit       stimulus_done;
    bit       calm;          // no idling while set
    int       errors;
    int       stall_cycles;

    // Acceptance seen at the last rising edge.
    logic s_ready_seen;

    // Software copy of the engine state.
    logic [31:0] hash_words[4];
    logic [7:0]  block_buf[64];
    logic [60:0] bytes_taken;

    localparam int SHIFTS[16] = '{7, 12, 17, 22, 5, 9, 14, 20, 4, 11, 16, 23, 6, 10, 15, 21};
    localparam logic [31:0] SINES[64] = '{
        32'hd76aa478, 32'he8c7b756, 32'h242070db, 32'hc1bdceee,
        32'hf57c0faf, 32'h4787c62a, 32'ha8304613, 32'hfd469501,
        32'h698098d8, 32'h8b44f7af, 32'hffff5bb1, 32'h895cd7be,
        32'h6b901122, 32'hfd987193, 32'ha679438e, 32'h49b40821,
        32'hf61e2562, 32'hc040b340, 32'h265e5a51, 32'he9b6c7aa,
        32'hd62f105d, 32'h02441453, 32'hd8a1e681, 32'he7d3fbc8,
        32'h21e1cde6, 32'hc33707d6, 32'hf4d50d87, 32'h455a14ed,
        32'ha9e3e905, 32'hfcefa3f8, 32'h676f02d9, 32'h8d2a4c8a,
        32'hfffa3942, 32'h8771f681, 32'h6d9d6122, 32'hfde5380c,
        32'ha4beea44, 32'h4bdecfa9, 32'hf6bb4b60, 32'hbebfbc70,
        32'h289b7ec6, 32'heaa127fa, 32'hd4ef3085, 32'h04881d05,
        32'hd9d4d039, 32'he6db99e5, 32'h1fa27cf8, 32'hc4ac5665,
        32'hf4292244, 32'h432aff97, 32'hab9423a7, 32'hfc93a039,
        32'h655b59c3, 32'h8f0ccc92, 32'hffeff47d, 32'h85845dd1,
        32'h6fa87e4f, 32'hfe2ce6e0, 32'ha3014314, 32'h4e0811a1,
        32'hf7537e82, 32'hbd3af235, 32'h2ad7d2bb, 32'heb86d391};

    function automatic void restart_hash();
        hash_words[0] = INIT_A;
        hash_words[1] = INIT_B;
        hash_words[2] = INIT_C;
        hash_words[3] = INIT_D;
        bytes_taken   = '0;
    endfunction

    function automatic void compress_buf();
        logic [31:0] msg[16];
        logic [31:0] a, b, c, d, f, sum;
        int          g, q;
        for (int k = 0; k < 16; k++)
            msg[k] = {block_buf[4*k+3], block_buf[4*k+2], block_buf[4*k+1], block_buf[4*k]};
        a = hash_words[0]; b = hash_words[1]; c = hash_words[2]; d = hash_words[3];
        for (int r = 0; r < 64; r++) begin
            q = r / 16;
            case (q)
                0: begin f = (b & c) | (~b & d); g = r; end
                1: begin f = (b & d) | (c & ~d); g = (5 * r + 1) % 16; end
                2: begin f = b ^ c ^ d;          g = (3 * r + 5) % 16; end
                default: begin f = c ^ (b | ~d); g = (7 * r) % 16; end
            endcase
            sum = a + f + SINES[r] + msg[g];
            a = d;
            d = c;
            c = b;
            b = b + ((sum << SHIFTS[q*4 + r%4]) | (sum >> (32 - SHIFTS[q*4 + r%4])));
        end
        hash_words[0] += a; hash_words[1] += b; hash_words[2] += c; hash_words[3] += d;
    endfunction

    // Advance the software digest by one accepted request.
    function automatic void absorb_request(md5_in_t req);
        int          fill;
        logic [63:0] bit_len;
        md5_out_t    o;
        if (req.has_byte) begin
            fill = int'(bytes_taken[5:0]);
            block_buf[fill] = req.data_byte;
            bytes_taken++;
            if (fill == 63)
                compress_buf();
        end
        if (req.end_of_message) begin
            fill = int'(bytes_taken[5:0]);
            bit_len = {bytes_taken, 3'b000};
            block_buf[fill] = 8'h80;
            fill++;
            if (fill > 56) begin
                while (fill < 64) begin
                    block_buf[fill] = 8'h00;
                    fill++;
                end
                compress_buf();
                fill = 0;
            end
            while (fill < 56) begin
                block_buf[fill] = 8'h00;
                fill++;
            end
            for (int k = 0; k < 8; k++)
                block_buf[56+k] = bit_len[8*k +: 8];
            compress_buf();
            for (int k = 0; k < 16; k++) begin
                o.digest_byte = hash_words[k/4][8*(k%4) +: 8];
                o.digest_last = (k == 15);
                digest_bytes_due.push_back(o);
            end
            restart_hash();
        end
    endfunction

    // end_mode: 0 random, 1 end flag on the last byte, 2 separate end request
    function automatic void queue_message(int len, int mode, int end_mode);
        md5_in_t r;
        for (int i = 0; i < len; i++) begin
            r.has_byte = 1'b1;
            case (mode)
                1: r.data_byte = 8'h00;
                2: r.data_byte = 8'hFF;
                default: r.data_byte = 8'($urandom_range(0, 255));
            endcase
            r.end_of_message = 1'b0;
            // sprinkle do-nothing requests
            if ($urandom_range(0, 19) == 0) begin
                pending_requests.push_back('{data_byte: 8'($urandom), has_byte: 1'b0,
                                             end_of_message: 1'b0});
            end
            // last byte either carries the end flag or an empty end follows
            if (i == len - 1 && (end_mode == 1
                                 || (end_mode == 0 && $urandom_range(0, 1) != 0)))
                r.end_of_message = 1'b1;
            pending_requests.push_back(r);
        end
        if (len == 0 || !pending_requests[$].end_of_message)
            pending_requests.push_back('{data_byte: 8'($urandom), has_byte: 1'b0,
                                         end_of_message: 1'b1});
    endfunction

    initial begin
        restart_hash();
        errors = 0;
        stimulus_done = 1'b0;
        calm = 1'b0;
        // Directed: empty message, single bytes at the extremes, lengths
        // around the one-block / two-block padding boundary.
        queue_message(0, 0, 0);
        queue_message(1, 1, 1);
        queue_message(1, 2, 2);
        queue_message(3, 0, 0);
        queue_message(55, 2, 1);
        queue_message(56, 1, 1);
        queue_message(63, 0, 2);
        queue_message(64, 0, 1);
        // Random short messages up to the request budget.
        while (pending_requests.size() < 262)
            queue_message($urandom_range(0, 6), 0, 0);
        stimulus_done = 1'b1;
    end

    // Driver: a new request can follow at the falling edge after acceptance.
    always @(negedge aclk) begin
        if (!aresetn) begin
            s_valid <= 1'b0;
            s_data  <= '0;
            m_ready <= 1'b0;
        end else begin
            if (!s_valid || s_ready_seen) begin
                if (pending_requests.size() > 0 && (calm || $urandom_range(0, 99) >= 13)) begin
                    s_data  <= pending_requests.pop_front();
                    s_valid <= 1'b1;
                end else begin
                    s_valid <= 1'b0;
                end
            end
            m_ready <= calm || ($urandom_range(0, 99) >= 13);
        end
    end

    always @(posedge aclk) begin
        if (!aresetn) begin
            s_ready_seen <= 1'b0;
            stall_cycles <= 0;
        end else begin
            s_ready_seen <= s_valid && s_ready;
            if (s_valid && s_ready)
                absorb_request(s_data);
            if ((s_valid && s_ready) || (m_valid && m_ready))
                stall_cycles <= 0;
            else
                stall_cycles <= stall_cycles + 1;
            // Monitor: compare each digest byte with the oldest expected one.
            if (m_valid && m_ready) begin
                if (digest_bytes_due.size() == 0) begin
                    $error("unexpected digest byte %02h", m_data.digest_byte);
                    errors++;
                end else begin
                    md5_out_t exp_byte;
                    exp_byte = digest_bytes_due.pop_front();
                    if (m_data.digest_byte !== exp_byte.digest_byte) begin
                        $error("digest_byte expected %02h got %02h",
                               exp_byte.digest_byte, m_data.digest_byte);
                        errors++;
                    end
                    if (m_data.digest_last !== exp_byte.digest_last) begin
                        $error("digest_last expected %0d got %0d",
                               exp_byte.digest_last, m_data.digest_last);
                        errors++;
                    end
                end
            end
        end
    end

    // Calm stretch: no idling in a window of the run.
    initial begin
        #20000;
        calm = 1'b1;
        #40000;
        calm = 1'b0;
    end

    initial begin
        aresetn = 1'b0;
        s_valid = 1'b0;
        s_data  = '0;
        m_ready = 1'b0;
        repeat (8) @(posedge aclk);
        @(negedge aclk);
        aresetn = 1'b1;
        wait (stimulus_done && pending_requests.size() == 0 && !s_valid
              && digest_bytes_due.size() == 0);
        repeat (200) @(posedge aclk);
        if (errors == 0 && digest_bytes_due.size() == 0)
            $display("All tests passed");
        else
            $display("Some tests failed");
        $finish;
    end

    // Watchdog: worst case is a two-block end; any transfer restarts the count.
    always @(posedge aclk) begin
        if (stall_cycles >= 5000) begin
            $display("Some tests failed");
            $finish;
        end
    end

endmodule
